// File: hw/rtl/bit_packed_record_parser_unit_assert.svh
// assertion macros used by the parser core rtl
`ifndef BIT_PACKED_RECORD_PARSER_UNIT_ASSERT_SVH
`define BIT_PACKED_RECORD_PARSER_UNIT_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define BPR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define BPR_NEVER(label, cond, msg) \
    `BPR_ASSERT(label, !(cond), msg)

`endif

// File: hw/rtl/bpr_pkg.sv
// types, codes and helper functions of the bit-packed record parser
package bpr_pkg;

    // parse phases of the record formats
    typedef enum logic [4:0] {
        PH_IDLE          = 5'd0,
        PH_RECT_NBITS    = 5'd1,
        PH_RECT_X1       = 5'd2,
        PH_RECT_X2       = 5'd3,
        PH_RECT_Y1       = 5'd4,
        PH_RECT_Y2       = 5'd5,
        PH_MAT_HAS_SCALE = 5'd6,
        PH_SCALE_NBITS   = 5'd7,
        PH_SCALE_X       = 5'd8,
        PH_SCALE_Y       = 5'd9,
        PH_MAT_HAS_SKEW  = 5'd10,
        PH_SKEW_NBITS    = 5'd11,
        PH_SKEW0         = 5'd12,
        PH_SKEW1         = 5'd13,
        PH_TRANS_NBITS   = 5'd14,
        PH_TRANS_X       = 5'd15,
        PH_TRANS_Y       = 5'd16,
        PH_CX_FLAGS      = 5'd17,
        PH_CX_NBITS      = 5'd18,
        PH_MUL_R         = 5'd19,
        PH_MUL_G         = 5'd20,
        PH_MUL_B         = 5'd21,
        PH_MUL_A         = 5'd22,
        PH_ADD_R         = 5'd23,
        PH_ADD_G         = 5'd24,
        PH_ADD_B         = 5'd25,
        PH_ADD_A         = 5'd26
    } phase_t;

    // record kinds
    localparam logic [1:0] KIND_RECT     = 2'd0;
    localparam logic [1:0] KIND_MATRIX   = 2'd1;
    localparam logic [1:0] KIND_CXFORM   = 2'd2;
    localparam logic [1:0] KIND_CXFORM_A = 2'd3;

    // header widths
    localparam logic [4:0] NBITS_HDR_W = 5'd5;
    localparam logic [4:0] FLAG_W      = 5'd1;
    localparam logic [4:0] CX_FLAGS_W  = 5'd2;
    localparam logic [4:0] CX_NBITS_W  = 5'd4;

    // field codes
    localparam logic [4:0] FC_RECT_X1  = 5'd0;
    localparam logic [4:0] FC_RECT_X2  = 5'd1;
    localparam logic [4:0] FC_RECT_Y1  = 5'd2;
    localparam logic [4:0] FC_RECT_Y2  = 5'd3;
    localparam logic [4:0] FC_SCALE_X  = 5'd4;
    localparam logic [4:0] FC_SCALE_Y  = 5'd5;
    localparam logic [4:0] FC_SKEW0    = 5'd6;
    localparam logic [4:0] FC_SKEW1    = 5'd7;
    localparam logic [4:0] FC_TRANS_X  = 5'd8;
    localparam logic [4:0] FC_TRANS_Y  = 5'd9;
    localparam logic [4:0] FC_MUL_R    = 5'd10;
    localparam logic [4:0] FC_MUL_G    = 5'd11;
    localparam logic [4:0] FC_MUL_B    = 5'd12;
    localparam logic [4:0] FC_MUL_A    = 5'd13;
    localparam logic [4:0] FC_ADD_R    = 5'd14;
    localparam logic [4:0] FC_ADD_G    = 5'd15;
    localparam logic [4:0] FC_ADD_B    = 5'd16;
    localparam logic [4:0] FC_ADD_A    = 5'd17;

    // one queued stream byte with its mode
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data;
    } item_t;

    // bits a phase consumes before it completes
    function automatic logic [4:0] bits_needed(phase_t p, logic [4:0] width);
        logic [4:0] n;
        begin
            case (p)
                PH_RECT_NBITS, PH_SCALE_NBITS, PH_SKEW_NBITS, PH_TRANS_NBITS: n = NBITS_HDR_W;
                PH_MAT_HAS_SCALE, PH_MAT_HAS_SKEW:                           n = FLAG_W;
                PH_CX_FLAGS:                                                 n = CX_FLAGS_W;
                PH_CX_NBITS:                                                 n = CX_NBITS_W;
                default:                                                     n = width;
            endcase
            return n;
        end
    endfunction

    // field code of a value phase, valid flag in the top bit
    function automatic logic [5:0] code_of(phase_t p);
        logic [5:0] c;
        begin
            case (p)
                PH_RECT_X1: c = {1'b1, FC_RECT_X1};
                PH_RECT_X2: c = {1'b1, FC_RECT_X2};
                PH_RECT_Y1: c = {1'b1, FC_RECT_Y1};
                PH_RECT_Y2: c = {1'b1, FC_RECT_Y2};
                PH_SCALE_X: c = {1'b1, FC_SCALE_X};
                PH_SCALE_Y: c = {1'b1, FC_SCALE_Y};
                PH_SKEW0:   c = {1'b1, FC_SKEW0};
                PH_SKEW1:   c = {1'b1, FC_SKEW1};
                PH_TRANS_X: c = {1'b1, FC_TRANS_X};
                PH_TRANS_Y: c = {1'b1, FC_TRANS_Y};
                PH_MUL_R:   c = {1'b1, FC_MUL_R};
                PH_MUL_G:   c = {1'b1, FC_MUL_G};
                PH_MUL_B:   c = {1'b1, FC_MUL_B};
                PH_MUL_A:   c = {1'b1, FC_MUL_A};
                PH_ADD_R:   c = {1'b1, FC_ADD_R};
                PH_ADD_G:   c = {1'b1, FC_ADD_G};
                PH_ADD_B:   c = {1'b1, FC_ADD_B};
                PH_ADD_A:   c = {1'b1, FC_ADD_A};
                default:    c = 6'd0;
            endcase
            return c;
        end
    endfunction

endpackage

// File: hw/rtl/bpr_in_queue.sv
// two-entry byte queue between the stream input and the parser
module bpr_in_queue
    import bpr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_pop,
    output item_t out_item
);

    item_t      mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    // handshake decode
    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: hw/rtl/bpr_parse_core.sv
// record parser: walks the bit stream of queued bytes and emits value fields
module bpr_parse_core
    import bpr_pkg::*;
#(
    parameter int VALUE_BITS = 31
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  item_t                 q_item,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [4:0]            res_code,
    output logic [VALUE_BITS-1:0] res_value,
    output logic                  res_last
);

    localparam logic signed [31:0] VMAX = (32'sd1 <<< (VALUE_BITS - 1)) - 32'sd1;
    localparam logic signed [31:0] VMIN = -(32'sd1 <<< (VALUE_BITS - 1));

    phase_t     phase_reg, phase_next;
    logic [1:0] kind_reg, kind_next;
    logic [4:0] width_reg, width_next;
    logic [4:0] coll_reg, coll_next;
    logic [30:0] part_reg, part_next;
    logic [1:0] flags_reg, flags_next;
    logic [7:0] byte_reg, byte_next;
    logic [3:0] left_reg, left_next;
    logic       busy_reg, busy_next;

    logic                  out_valid_reg;
    logic [4:0]            out_code_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic                  out_last_reg;

    logic [4:0]  need;
    logic [4:0]  rem;
    logic [3:0]  take;
    logic [7:0]  got;
    logic [8:0]  take_mask;
    logic [4:0]  coll_sum;
    logic [30:0] part_sum;
    logic        complete;
    logic [5:0]  code_info;
    logic        is_value;
    logic        emit;
    logic        stall;
    logic        field_last;
    phase_t      after_mul;
    phase_t      nxt;
    logic [5:0]  sh_amt;
    logic [31:0] raw_shl;
    logic signed [31:0] sext;
    logic signed [31:0] sat;

    // bit intake: take as many bits of the byte as the current item still needs, at most the bits left in it
    always_comb
    begin
        need      = bits_needed(phase_reg, width_reg);
        rem       = need - coll_reg;
        take      = ({1'b0, left_reg} < rem) ? left_reg : rem[3:0];
        take_mask = (9'd1 << take) - 9'd1;
        got       = (byte_reg >> (left_reg - take)) & take_mask[7:0];
        coll_sum  = coll_reg + {1'b0, take};
        part_sum  = (part_reg << take) | {23'd0, got};
        complete  = (coll_sum == need);
        code_info = code_of(phase_reg);
        is_value  = code_info[5];
    end

    // sign extension from the field width and saturation to the output range
    always_comb
    begin
        sh_amt  = 6'd32 - {1'b0, width_reg};
        raw_shl = {1'b0, part_sum} << sh_amt;
        sext    = $signed(raw_shl) >>> sh_amt;
        if (width_reg == 5'd0)
        begin
            sat = 32'sd0;
        end
        else if (sext > VMAX)
        begin
            sat = VMAX;
        end
        else if (sext < VMIN)
        begin
            sat = VMIN;
        end
        else
        begin
            sat = sext;
        end
    end

    // phase that follows a completed item
    always_comb
    begin
        after_mul = flags_reg[1] ? PH_ADD_R : PH_IDLE;
        case (phase_reg)
            PH_RECT_Y2, PH_TRANS_Y, PH_ADD_A: nxt = PH_IDLE;
            PH_SCALE_Y:       nxt = PH_MAT_HAS_SKEW;
            PH_SKEW1:         nxt = PH_TRANS_NBITS;
            PH_MUL_B:         nxt = (kind_reg == KIND_CXFORM_A) ? PH_MUL_A : after_mul;
            PH_MUL_A:         nxt = after_mul;
            PH_ADD_B:         nxt = (kind_reg == KIND_CXFORM_A) ? PH_ADD_A : PH_IDLE;
            PH_MAT_HAS_SCALE: nxt = part_sum[0] ? PH_SCALE_NBITS : PH_MAT_HAS_SKEW;
            PH_MAT_HAS_SKEW:  nxt = part_sum[0] ? PH_SKEW_NBITS : PH_TRANS_NBITS;
            PH_CX_FLAGS:      nxt = PH_CX_NBITS;
            PH_CX_NBITS:      nxt = flags_reg[0] ? PH_MUL_R : after_mul;
            PH_IDLE:          nxt = PH_IDLE;
            PH_RECT_NBITS, PH_RECT_X1, PH_RECT_X2, PH_RECT_Y1, PH_SCALE_NBITS,
            PH_SCALE_X, PH_SKEW_NBITS, PH_SKEW0, PH_TRANS_NBITS, PH_TRANS_X,
            PH_MUL_R, PH_MUL_G, PH_ADD_R, PH_ADD_G:
                              nxt = phase_t'(phase_reg + 5'd1);
            default:          nxt = PH_IDLE;
        endcase
    end

    // control outputs of a step
    always_comb
    begin
        stall      = busy_reg && complete && is_value && out_valid_reg && !res_ready;
        emit       = busy_reg && complete && is_value && !stall;
        field_last = (nxt == PH_IDLE);
        q_pop      = !busy_reg;
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        width_next = width_reg;
        coll_next  = coll_reg;
        part_next  = part_reg;
        flags_next = flags_reg;
        byte_next  = byte_reg;
        left_next  = left_reg;
        busy_next  = busy_reg;
        if (!busy_reg)
        begin
            if (q_valid)
            begin
                byte_next = q_item.data;
                left_next = 4'd8;
                busy_next = 1'b1;
                if (phase_reg == PH_IDLE)
                begin
                    kind_next = q_item.mode;
                    coll_next = 5'd0;
                    part_next = 31'd0;
                    case (q_item.mode)
                        KIND_RECT:   phase_next = PH_RECT_NBITS;
                        KIND_MATRIX: phase_next = PH_MAT_HAS_SCALE;
                        default:     phase_next = PH_CX_FLAGS;
                    endcase
                end
            end
        end
        else if (!stall)
        begin
            left_next = left_reg - take;
            coll_next = coll_sum;
            part_next = part_sum;
            if (complete)
            begin
                coll_next  = 5'd0;
                part_next  = 31'd0;
                phase_next = nxt;
                case (phase_reg)
                    PH_RECT_NBITS, PH_SCALE_NBITS, PH_SKEW_NBITS, PH_TRANS_NBITS:
                        width_next = part_sum[4:0];
                    PH_CX_FLAGS:
                        flags_next = part_sum[1:0];
                    PH_CX_NBITS:
                        width_next = {1'b0, part_sum[3:0]};
                    default:
                        width_next = width_reg;
                endcase
                if (nxt == PH_IDLE)
                begin
                    busy_next = 1'b0;
                end
            end
            else if (left_reg == take)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            kind_reg      <= 2'd0;
            width_reg     <= 5'd0;
            coll_reg      <= 5'd0;
            part_reg      <= 31'd0;
            flags_reg     <= 2'd0;
            left_reg      <= 4'd0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            width_reg <= width_next;
            coll_reg  <= coll_next;
            part_reg  <= part_next;
            flags_reg <= flags_next;
            left_reg  <= left_next;
            busy_reg  <= busy_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // current byte and result payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        if (emit)
        begin
            out_code_reg  <= code_info[4:0];
            out_value_reg <= sat[VALUE_BITS-1:0];
            out_last_reg  <= field_last;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_code  = out_code_reg;
    assign res_value = out_value_reg;
    assign res_last  = out_last_reg;

    `include "bit_packed_record_parser_unit_assert.svh"

    `BPR_ASSERT(a_coll_in_range, busy_reg |-> (coll_reg <= need), "bits gathered exceed need")
    `BPR_ASSERT(a_left_in_range, left_reg <= 4'd8, "bits left in byte out of range")
    `BPR_NEVER(a_busy_idle, busy_reg && (phase_reg == PH_IDLE), "byte loaded without a record")
    `BPR_ASSERT(a_stall_holds, stall |=> ($stable(phase_reg) && $stable(left_reg)), "stalled step moved")

endmodule

// File: hw/rtl/bit_packed_record_parser_unit.sv
// bit-packed record parser: top level
// Input stream s_axis: one byte per transaction, consumed most significant bit
// first; tuser carries the record kind (0 rect, 1 matrix, 2 cxform, 3 cxform
// with alpha) and is looked at only on the first byte of a record.
// Output stream m_axis: one transaction per value field present in the record,
// field code and sign-extended, saturated raw value in tdata, tlast on the record's last
// field. Absent fields produce nothing; the rest of the last byte is dropped.
// Timing: a byte enters a two-entry queue and is loaded by the parser once the
// parser has finished the byte before it; each further parser cycle completes one
// header or field (or ends the byte) unless the receiver stalls; a field result
// appears on m_axis the cycle after it completes. A byte takes a load step, a
// step for each header or field it completes and, unless the record ends in it,
// a step that finds it used up; at most one result per cycle unless the receiver
// stalls; the single parser step per cycle sets this rate.
// Reset clears the queue, the parser state and the output valid flag; parsing
// starts with a new record. When the receiver stalls, the parser holds at the
// next field and the queue keeps taking bytes until both entries are full.
module bit_packed_record_parser_unit
    import bpr_pkg::*;
#(
    parameter int VALUE_BITS = 31
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // stream_byte
    input  logic [1:0]                          s_axis_tuser,  // mode
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // field_code [4:0], field_value above it, zero padded to whole bytes
    output logic [((5 + VALUE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic                                m_axis_tlast   // record_end
);

    localparam int OUT_W = ((5 + VALUE_BITS + 7) / 8) * 8;

    item_t                 in_item;
    item_t                 q_item;
    logic                  q_valid;
    logic                  q_pop;
    logic [4:0]            res_code;
    logic [VALUE_BITS-1:0] res_value;

    // input packing
    always_comb
    begin
        in_item.data = s_axis_tdata;
        in_item.mode = s_axis_tuser;
    end

    bpr_in_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_item  (q_item)
    );

    bpr_parse_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_code  (res_code),
        .res_value (res_value),
        .res_last  (m_axis_tlast)
    );

    // output packing
    assign m_axis_tdata = OUT_W'({res_value, res_code});

endmodule

// File: tb/bit_packed_record_parser_unit_tb.sv
// testbench for the bit-packed record parser: directed and random streams checked against a local parser
`timescale 1ns / 1ps

module bit_packed_record_parser_unit_tb;
    import bpr_pkg::*;

    localparam int VBITS = 31;
    localparam int TDW = ((5 + VBITS + 7) / 8) * 8;
    localparam int RING_DEPTH = 64;

    // one emitted field
    typedef struct {
        logic [4:0]       code;
        logic [VBITS-1:0] value;
        logic             last;
    } field_t;

    // scoreboard: parser state and ring of pending fields
    class field_scoreboard;
        logic [1:0]  kind;
        phase_t      phase;
        logic [4:0]  width;
        logic [4:0]  nbits;
        logic [30:0] acc;
        logic [1:0]  flags;
        field_t      ring[RING_DEPTH];
        int          head;
        int          tail;
        int          errors;

        function void clear();
            kind = KIND_RECT;
            phase = PH_IDLE;
            width = '0;
            nbits = '0;
            acc = '0;
            flags = '0;
            errors = 0;
            head = 0;
            tail = 0;
        endfunction

        // number of fields still expected
        function int level();
            return tail - head;
        endfunction

        function void add_field(field_t f);
            ring[tail % RING_DEPTH] = f;
            tail++;
        endfunction

        function field_t take_field();
            field_t f;
            f = ring[head % RING_DEPTH];
            head++;
            return f;
        endfunction

        function logic [4:0] need(phase_t p);
            case (p)
                PH_RECT_NBITS, PH_SCALE_NBITS, PH_SKEW_NBITS, PH_TRANS_NBITS: return 5'd5;
                PH_MAT_HAS_SCALE, PH_MAT_HAS_SKEW: return 5'd1;
                PH_CX_FLAGS: return 5'd2;
                PH_CX_NBITS: return 5'd4;
                default: return width;
            endcase
        endfunction

        function bit is_value(phase_t p);
            return (p >= PH_RECT_X1 && p <= PH_RECT_Y2) || p == PH_SCALE_X || p == PH_SCALE_Y
                || p == PH_SKEW0 || p == PH_SKEW1 || p == PH_TRANS_X || p == PH_TRANS_Y
                || (p >= PH_MUL_R && p <= PH_ADD_A);
        endfunction

        function logic [4:0] field_code(phase_t p);
            if (p <= PH_RECT_Y2) return 5'(p - 2);
            if (p <= PH_SCALE_Y) return 5'(p - 4);
            if (p <= PH_SKEW1) return 5'(p - 6);
            if (p <= PH_TRANS_Y) return 5'(p - 7);
            return 5'(p - 9);
        endfunction

        function phase_t after_mul();
            return flags[1] ? PH_ADD_R : PH_IDLE;
        endfunction

        function phase_t next_value(phase_t p);
            case (p)
                PH_RECT_Y2, PH_TRANS_Y, PH_ADD_A: return PH_IDLE;
                PH_SCALE_Y: return PH_MAT_HAS_SKEW;
                PH_SKEW1: return PH_TRANS_NBITS;
                PH_MUL_B: return (kind == KIND_CXFORM_A) ? PH_MUL_A : after_mul();
                PH_MUL_A: return after_mul();
                PH_ADD_B: return (kind == KIND_CXFORM_A) ? PH_ADD_A : PH_IDLE;
                default: return phase_t'(p + 1);
            endcase
        endfunction

        // sign-extend raw bits of width w, saturate to VBITS
        function logic [VBITS-1:0] extend(logic [30:0] raw, logic [4:0] w);
            longint v;
            longint lim;
            lim = longint'(1) << (VBITS - 1);
            if (w == 0) return '0;
            v = raw & ((longint'(1) << w) - 1);
            if ((v >> (w - 1)) & 1) v -= longint'(1) << w;
            if (v > lim - 1) v = lim - 1;
            if (v < -lim) v = -lim;
            return v[VBITS-1:0];
        endfunction

        // note an accepted byte, queue the fields it completes
        function void note_byte(logic [7:0] b, logic [1:0] mode);
            int left;
            phase_t p;
            phase_t nx;
            logic [30:0] v;
            field_t f;
            left = 8;
            if (phase == PH_IDLE)
            begin
                kind = mode;
                case (mode)
                    KIND_RECT:   phase = PH_RECT_NBITS;
                    KIND_MATRIX: phase = PH_MAT_HAS_SCALE;
                    default:     phase = PH_CX_FLAGS;
                endcase
                nbits = '0;
                acc = '0;
            end
            forever
            begin
                p = phase;
                if (p == PH_IDLE) break;
                if (nbits >= need(p))
                begin
                    v = acc;
                    nbits = '0;
                    acc = '0;
                    if (is_value(p))
                    begin
                        nx = next_value(p);
                        f.code = field_code(p);
                        f.value = extend(v, width);
                        f.last = (nx == PH_IDLE);
                        add_field(f);
                        phase = nx;
                    end
                    else if (p == PH_MAT_HAS_SCALE)
                    begin
                        phase = v[0] ? PH_SCALE_NBITS : PH_MAT_HAS_SKEW;
                    end
                    else if (p == PH_MAT_HAS_SKEW)
                    begin
                        phase = v[0] ? PH_SKEW_NBITS : PH_TRANS_NBITS;
                    end
                    else if (p == PH_CX_FLAGS)
                    begin
                        flags = v[1:0];
                        phase = PH_CX_NBITS;
                    end
                    else if (p == PH_CX_NBITS)
                    begin
                        width = {1'b0, v[3:0]};
                        phase = flags[0] ? PH_MUL_R : after_mul();
                    end
                    else
                    begin
                        width = v[4:0];
                        phase = phase_t'(p + 1);
                    end
                    if (phase == PH_IDLE) break;
                    continue;
                end
                if (left == 0) break;
                left--;
                acc = {acc[29:0], b[left]};
                nbits++;
            end
        endfunction

        // compare one output transaction with the oldest pending field
        function void check_field(logic [TDW-1:0] data, logic last);
            field_t f;
            if (level() == 0)
            begin
                $error("unexpected field: code %0d value %0h", data[4:0], data[5 +: VBITS]);
                errors++;
                return;
            end
            f = take_field();
            if (data[4:0] !== f.code)
            begin
                $error("field_code: expected %0d, actual %0d", f.code, data[4:0]);
                errors++;
            end
            if (data[5 +: VBITS] !== f.value)
            begin
                $error("field_value: expected %0h, actual %0h", f.value, data[5 +: VBITS]);
                errors++;
            end
            if (last !== f.last)
            begin
                $error("record_end: expected %0b, actual %0b", f.last, last);
                errors++;
            end
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [7:0]      s_axis_tdata;   // stream_byte
    logic [1:0]      s_axis_tuser;   // mode
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [TDW-1:0]  m_axis_tdata;   // field_code [4:0], field_value [35:5], zero pad
    logic            m_axis_tlast;   // record_end

    field_scoreboard board;
    bit              stall_on;

    bit_packed_record_parser_unit #(.VALUE_BITS(VBITS)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver stall pattern and result check
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_field(m_axis_tdata, m_axis_tlast);
        if (!stall_on)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // send one byte, hold until the transaction completes
    task automatic send_byte(input logic [7:0] b, input logic [1:0] mode);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= mode;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        board.note_byte(b, mode);
    endtask

    // drop valid for a random gap
    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // send a byte sequence, with random gaps between bytes when gaps is set
    task automatic send_bytes(input logic [7:0] bytes[$], input logic [1:0] mode, input bit gaps);
        foreach (bytes[i])
        begin
            send_byte(bytes[i], mode);
            if (gaps && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 4));
        end
    endtask

    // drive bytes until the record in progress closes
    task automatic finish_record();
        int guard;
        guard = 0;
        while (board.phase != PH_IDLE && guard < 40)
        begin
            send_byte(8'($urandom), 2'($urandom));
            guard++;
        end
    endtask

    initial
    begin
        logic [7:0] seq[$];
        logic [1:0] mode;
        int n;
        board = new();
        board.clear();
        stall_on = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tuser = 2'b00;
        m_axis_tready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rect, width 31, extreme values
        seq = '{8'hFF, 8'hC0, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hF0};
        send_bytes(seq, KIND_RECT, 1'b0);
        finish_record();
        // rect with zero width: all four emitted on first byte
        seq = '{8'h00};
        send_bytes(seq, KIND_RECT, 1'b0);
        // matrix: no scale, no skew, zero-width translate
        seq = '{8'h00};
        send_bytes(seq, KIND_MATRIX, 1'b0);
        // matrix with everything, then mode changing mid record
        seq = '{8'hC4, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC};
        send_bytes(seq, KIND_MATRIX, 1'b0);
        finish_record();
        // empty cxform, cxform with both flags, cxform alpha
        seq = '{8'h0F};
        send_bytes(seq, KIND_CXFORM, 1'b0);
        seq = '{8'hFF, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'hFF, 8'h80, 8'h01};
        send_bytes(seq, KIND_CXFORM_A, 1'b0);
        finish_record();
        seq = '{8'hF0};
        send_bytes(seq, KIND_CXFORM_A, 1'b0);
        seq = '{8'h50};
        send_bytes(seq, KIND_CXFORM, 1'b0);

        // random records with random input gaps and receiver stalls
        stall_on = 1'b1;
        n = 0;
        while (n < 120)
        begin
            mode = 2'($urandom_range(0, 3));
            send_byte(8'($urandom), mode);
            n++;
            while (board.phase != PH_IDLE)
            begin
                if ($urandom_range(0, 4) == 0) idle_gap($urandom_range(1, 6));
                if ($urandom_range(0, 15) == 0) stall_on = ~stall_on;
                send_byte(8'($urandom), 2'($urandom));
                n++;
            end
        end
        s_axis_tvalid <= 1'b0;
        stall_on = 1'b0;

        while (board.level() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // overall time limit
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
